// ----- hdl/fixed_timestep_frame_scheduler_defines.svh -----
// Assertion macros for the frame scheduler checker.
// Depends on nothing.
`ifndef FIXED_TIMESTEP_FRAME_SCHEDULER_DEFINES_SVH
`define FIXED_TIMESTEP_FRAME_SCHEDULER_DEFINES_SVH
// clocked implication, disabled during reset
`define FTFS_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication, disabled during reset
`define FTFS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ----- hdl/ftfs_pkg.sv -----
// Package for the fixed-timestep frame scheduler: widths, codes, payload types.
// Depends on nothing.
package ftfs_pkg;
   localparam int TimeWidth = 63;
   localparam int CntWidth  = 64;
   localparam int UpdWidth  = 32;
   localparam int CsrAddrWidth = 2;

   localparam logic [CsrAddrWidth-1:0] CsrStep      = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CsrMaxFrame  = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CsrMaxUpdate = 2'd2;

   localparam logic [2:0] StatusOk        = 3'd0;
   localparam logic [2:0] StatusNegative  = 3'd1;
   localparam logic [2:0] StatusFrameFull = 3'd2;
   localparam logic [2:0] StatusAccOvf    = 3'd3;
   localparam logic [2:0] StatusDropOvf   = 3'd4;
   localparam logic [2:0] StatusSimOvf    = 3'd5;
   localparam logic [2:0] StatusDropTotOvf= 3'd6;
   localparam logic [2:0] StatusTickOvf   = 3'd7;

   localparam logic CmdAdvance = 1'b0;
   localparam logic CmdClear   = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [63:0] elapsed_ns;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [CntWidth-1:0]  frame_number;
      logic [CntWidth-1:0]  first_tick;
      logic [UpdWidth-1:0]  update_count;
      logic [TimeWidth-1:0] accepted_ns;
      logic [TimeWidth-1:0] dropped_ns;
      logic [TimeWidth-1:0] remainder_ns;
      logic [UpdWidth-1:0]  blend_fraction;
      logic                 clamped;
      logic                 limit_hit;
      logic [TimeWidth-1:0] simulated_total_ns;
      logic [TimeWidth-1:0] dropped_total_ns;
   } rsp_type;

   typedef struct packed {
      logic [CsrAddrWidth-1:0] index;
      logic [63:0]             data;
   } csr_type;
endpackage

// ----- hdl/ftfs_if.sv -----
// Valid/ready channel interfaces for the frame scheduler.
// Depends on ftfs_pkg.
interface ftfs_req_if;
   logic valid;
   logic ready;
   ftfs_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ftfs_rsp_if;
   logic valid;
   logic ready;
   ftfs_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ftfs_csr_if;
   logic valid;
   logic ready;
   ftfs_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fixed_timestep_frame_scheduler.sv -----
// Fixed-timestep frame scheduler: one shared 64-bit add/subtract unit under a one-hot
// sequencer. Depends on ftfs_pkg and ftfs_if.
// Clear goes straight to the response. Advance runs a check, where a negative, full counter
// or accumulator overflow ends it, then a 64-step divide, a 32-step and a 63-step multiply,
// 6 check steps, where a later overflow ends it, and a 32-step fraction. A new request is
// taken only after the last response transfer. Sync reset clears state, loads defaults.
module fixed_timestep_frame_scheduler (
   input logic clock,
   input logic reset,
   ftfs_req_if.sink req,
   ftfs_rsp_if.source rsp,
   ftfs_csr_if.sink csr
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_CHK  = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_MULP = 8'b0000_1000,
      S_MULD = 8'b0001_0000,
      S_POST = 8'b0010_0000,
      S_FRAC = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [62:0] step_ff, maxf_ff;
   logic [31:0] maxu_ff;
   logic [62:0] pend_ff, simt_ff, dropt_ff;
   logic [63:0] frames_ff, ticks_ff;
   logic [63:0] raw_ff;
   logic [62:0] acc_ff, cdrop_ff, sum_ff, ldrop_ff, prod_ff;
   logic [63:0] quo_ff, rem_ff;
   logic [63:0] mq_ff;
   logic [6:0]  cnt_ff;
   logic        clamp_ff, lhit_ff;
   logic [31:0] sched_ff;
   ftfs_pkg::rsp_type out_ff;
   logic [63:0] a_op, b_op, alu_sum, alu_diff;
   logic        alu_borrow;
   logic [62:0] step_eff;
   logic [63:0] avail_m;
   logic [63:0] div_q;
   logic        clip_c;
   logic [62:0] acc_c;
   logic [2:0]  chk_status;

   assign step_eff = (step_ff == '0) ? 63'd1 : step_ff;
   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = out_ff;
   assign alu_sum = a_op + b_op;
   assign {alu_borrow, alu_diff} = {1'b0, a_op} - {1'b0, b_op};
   assign avail_m = quo_ff - {32'd0, sched_ff};
   assign div_q = {quo_ff[62:0], !alu_borrow};
   assign clip_c = raw_ff > {1'b0, maxf_ff};
   assign acc_c = clip_c ? maxf_ff : raw_ff[62:0];

   always_comb begin
      priority if (raw_ff[63]) chk_status = ftfs_pkg::StatusNegative;
      else if (frames_ff == '1) chk_status = ftfs_pkg::StatusFrameFull;
      else if ({1'b0, pend_ff} + {1'b0, acc_c} > 64'h7FFF_FFFF_FFFF_FFFF)
         chk_status = ftfs_pkg::StatusAccOvf;
      else chk_status = ftfs_pkg::StatusOk;
   end

   // shared unit operand select
   always_comb begin
      a_op = '0;
      b_op = '0;
      unique case (state_ff)
         S_DIV, S_FRAC: begin
            a_op = {rem_ff[62:0], (state_ff == S_DIV) ? mq_ff[63] : 1'b0};
            b_op = {1'b0, step_eff};
         end
         S_MULP: begin
            a_op = {prod_ff, 1'b0};
            b_op = {1'b0, step_eff};
         end
         S_MULD: begin
            a_op = {1'b0, ldrop_ff};
            b_op = mq_ff[0] ? ({1'b0, step_eff} << cnt_ff[5:0]) : 64'd0;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) state_in = (req.data.cmd == ftfs_pkg::CmdClear) ? S_OUT : S_CHK;
         S_CHK:  state_in = (chk_status != ftfs_pkg::StatusOk) ? S_OUT : S_DIV;
         S_DIV:  if (cnt_ff == 7'd63) state_in = S_MULP;
         S_MULP: if (cnt_ff == 7'd31) state_in = S_MULD;
         S_MULD: if (cnt_ff == 7'd62) state_in = S_POST;
         S_POST: state_in = (cnt_ff == 7'd5) ? ((out_ff.status != ftfs_pkg::StatusOk) ?
                            S_OUT : S_FRAC) : S_POST;
         S_FRAC: if (cnt_ff == 7'd31) state_in = S_OUT;
         S_OUT:  if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 63'd16666667;
         maxf_ff <= 63'd250000000;
         maxu_ff <= 32'd8;
         pend_ff <= '0; simt_ff <= '0; dropt_ff <= '0;
         frames_ff <= '0; ticks_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && state_ff == S_IDLE) begin
            unique case (csr.data.index)
               ftfs_pkg::CsrStep:      step_ff <= csr.data.data[62:0];
               ftfs_pkg::CsrMaxFrame:  maxf_ff <= csr.data.data[62:0];
               ftfs_pkg::CsrMaxUpdate: maxu_ff <= csr.data.data[31:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               out_ff <= '0;
               raw_ff <= req.data.elapsed_ns;
               cnt_ff <= '0;
               if (req.data.cmd == ftfs_pkg::CmdClear) begin
                  pend_ff <= '0; simt_ff <= '0; dropt_ff <= '0;
                  frames_ff <= '0; ticks_ff <= '0;
               end
            end
            S_CHK: begin
               clamp_ff <= clip_c;
               acc_ff <= acc_c;
               cdrop_ff <= clip_c ? raw_ff[62:0] - maxf_ff : '0;
               sum_ff <= pend_ff + acc_c;
               mq_ff <= {1'b0, pend_ff + acc_c};
               rem_ff <= '0;
               quo_ff <= '0;
               prod_ff <= '0;
               ldrop_ff <= '0;
               out_ff.status <= chk_status;
            end
            S_DIV: begin
               cnt_ff <= (cnt_ff == 7'd63) ? 7'd0 : cnt_ff + 7'd1;
               mq_ff <= {mq_ff[62:0], 1'b0};
               rem_ff <= !alu_borrow ? alu_diff : a_op;
               quo_ff <= div_q;
               if (cnt_ff == 7'd63) begin
                  sched_ff <= (div_q < {32'd0, maxu_ff}) ? div_q[31:0] : maxu_ff;
               end
            end
            S_MULP: begin
               // processed = sched * step, sched is 32 bit: shift-add from MSB
               cnt_ff <= (cnt_ff == 7'd31) ? 7'd0 : cnt_ff + 7'd1;
               prod_ff <= sched_ff[5'd31 - cnt_ff[4:0]] ? alu_sum[62:0] : a_op[62:0];
               if (cnt_ff == 7'd31) begin
                  mq_ff <= avail_m;
                  lhit_ff <= quo_ff > {32'd0, maxu_ff};
               end
            end
            S_MULD: begin
               cnt_ff <= (cnt_ff == 7'd62) ? 7'd0 : cnt_ff + 7'd1;
               mq_ff <= {1'b0, mq_ff[63:1]};
               ldrop_ff <= alu_sum[62:0];
            end
            S_POST: begin
               cnt_ff <= (cnt_ff == 7'd5) ? 7'd0 : cnt_ff + 7'd1;
               unique case (cnt_ff)
                  7'd0: rem_ff <= {1'b0, sum_ff - prod_ff - ldrop_ff};
                  7'd1: if ({1'b0, cdrop_ff} + {1'b0, ldrop_ff} > 64'h7FFF_FFFF_FFFF_FFFF)
                           out_ff.status <= ftfs_pkg::StatusDropOvf;
                  7'd2: if (out_ff.status == ftfs_pkg::StatusOk &&
                            {1'b0, simt_ff} + {1'b0, prod_ff} > 64'h7FFF_FFFF_FFFF_FFFF)
                           out_ff.status <= ftfs_pkg::StatusSimOvf;
                  7'd3: if (out_ff.status == ftfs_pkg::StatusOk &&
                            {1'b0, dropt_ff} + {1'b0, cdrop_ff + ldrop_ff} >
                            64'h7FFF_FFFF_FFFF_FFFF)
                           out_ff.status <= ftfs_pkg::StatusDropTotOvf;
                  7'd4: if (out_ff.status == ftfs_pkg::StatusOk &&
                            ticks_ff > ~{32'd0, sched_ff})
                           out_ff.status <= ftfs_pkg::StatusTickOvf;
                  default: begin
                     quo_ff <= '0;
                  end
               endcase
            end
            S_FRAC: begin
               cnt_ff <= cnt_ff + 7'd1;
               rem_ff <= !alu_borrow ? alu_diff : a_op;
               quo_ff <= div_q;
               if (cnt_ff == 7'd31) begin
                  out_ff.frame_number <= frames_ff;
                  out_ff.first_tick <= ticks_ff;
                  out_ff.update_count <= sched_ff;
                  out_ff.accepted_ns <= acc_ff;
                  out_ff.dropped_ns <= cdrop_ff + ldrop_ff;
                  out_ff.remainder_ns <= sum_ff - prod_ff - ldrop_ff;
                  out_ff.blend_fraction <= div_q[31:0];
                  out_ff.clamped <= clamp_ff;
                  out_ff.limit_hit <= lhit_ff;
                  out_ff.simulated_total_ns <= simt_ff + prod_ff;
                  out_ff.dropped_total_ns <= dropt_ff + cdrop_ff + ldrop_ff;
                  pend_ff <= sum_ff - prod_ff - ldrop_ff;
                  simt_ff <= simt_ff + prod_ff;
                  dropt_ff <= dropt_ff + cdrop_ff + ldrop_ff;
                  ticks_ff <= ticks_ff + {32'd0, sched_ff};
                  frames_ff <= frames_ff + 64'd1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- hdl/ftfs_checker.sv -----
// Port-level checker for the frame scheduler, bound to the top level.
// Depends on the defines header.
`include "fixed_timestep_frame_scheduler_defines.svh"
module ftfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [63:0] rsp_frame_number
);
   `FTFS_ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !req_ready)
   `FTFS_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   `FTFS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status))
   `FTFS_ASSERT_IMPL(a_err, clock, reset, rsp_status != 3'd0 && rsp_valid, rsp_frame_number == '0)
endmodule

bind fixed_timestep_frame_scheduler ftfs_checker u_ftfs_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status), .rsp_frame_number(rsp.data.frame_number)
);
